@@ hdl/cpss_pkg.sv @@
// Shared types, constants and decode helpers for the cable pin short scanner.
// No dependencies; every other file of the block uses this package.
package cpss_pkg;

  localparam int PIN_W       = 5;
  localparam int LEVEL_BITS  = 19;
  localparam int DIGIT_COUNT = 4;
  localparam int POS_W       = 2;
  localparam int SEG_W       = 8;
  localparam int REFRESH_W   = 8;
  localparam int OP_W        = 2;

  localparam logic [REFRESH_W-1:0] REFRESH_RESET = 8'd6;
  localparam logic [3:0]           BLANK_CODE    = 4'd10;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_PROBE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_OK    = 2'd1,
    MODE_SHORT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PROBE = 2'd1,
    ST_FIND  = 2'd2,
    ST_EMIT  = 2'd3
  } seq_state_t;

  // Result currently on display; pin and partner read 0 unless a short is shown.
  typedef struct packed {
    mode_t            mode;
    logic [PIN_W-1:0] pin;
    logic [PIN_W-1:0] partner;
  } shown_t;

  // Sequencer status toward the channel logic.
  typedef struct packed {
    logic ready;
    logic emit;
  } seq_stat_t;

  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Tens digit of a pin number; blank code when the tens are zero.
  function automatic logic [3:0] tens_code(input logic [PIN_W-1:0] v);
    logic [3:0] t;
    if (v >= 5'd30)      t = 4'd3;
    else if (v >= 5'd20) t = 4'd2;
    else if (v >= 5'd10) t = 4'd1;
    else                 t = BLANK_CODE;
    return t;
  endfunction

  function automatic logic [3:0] units_code(input logic [PIN_W-1:0] v);
    logic [PIN_W-1:0] u;
    if (v >= 5'd30)      u = v - 5'd30;
    else if (v >= 5'd20) u = v - 5'd20;
    else if (v >= 5'd10) u = v - 5'd10;
    else                 u = v;
    return u[3:0];
  endfunction

endpackage

@@ hdl/cpss_ifs.sv @@
// Handshake interfaces of the cable pin short scanner: item, result and config.
// Depends on cpss_pkg for field widths.
interface cpss_item_if;
  logic                          valid;
  logic                          ready;
  logic [cpss_pkg::OP_W-1:0]       op;
  logic [cpss_pkg::LEVEL_BITS-1:0] levels;

  modport source (output valid, output op, output levels, input ready);
  modport sink   (input valid, input op, input levels, output ready);
endinterface

interface cpss_result_if;
  logic                       valid;
  logic                       ready;
  logic [cpss_pkg::PIN_W-1:0] drive_pin;
  logic                       scanning;
  logic [cpss_pkg::POS_W-1:0] digit_select;
  logic [cpss_pkg::SEG_W-1:0] segment_bits;
  logic [cpss_pkg::PIN_W-1:0] shown_pin;
  logic [cpss_pkg::PIN_W-1:0] shown_partner;
  logic                       all_ok;

  modport source (output valid, output drive_pin, output scanning, output digit_select,
                  output segment_bits, output shown_pin, output shown_partner,
                  output all_ok, input ready);
  modport sink   (input valid, input drive_pin, input scanning, input digit_select,
                  input segment_bits, input shown_pin, input shown_partner,
                  input all_ok, output ready);
endinterface

interface cpss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpss_pkg::REFRESH_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/cpss_seq.sv @@
// Scan sequencer: short table, one shared pin-walk test unit and its control FSM.
// Depends on cpss_pkg.
module cpss_seq #(
  parameter int PIN_COUNT = 19
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             acc,
  input  logic [cpss_pkg::OP_W-1:0]        op,
  input  logic [cpss_pkg::LEVEL_BITS-1:0]  levels,
  input  logic                             take,
  output cpss_pkg::seq_stat_t              stat,
  output cpss_pkg::shown_t                 shown,
  output logic [cpss_pkg::PIN_W-1:0]       drive_pin,
  output logic                             scanning
);
  import cpss_pkg::*;

  localparam int IDX_W = $clog2(PIN_COUNT);
  localparam logic [PIN_W-1:0] LAST_PIN  = PIN_W'(PIN_COUNT);
  localparam logic [PIN_W-1:0] LAST_STEP = PIN_W'(PIN_COUNT - 1);
  localparam logic [PIN_W-1:0] PIN_ONE   = PIN_W'(1);
  localparam int LV_PAD = (2 ** PIN_W) - LEVEL_BITS;

  seq_state_t state, state_next;

  logic [PIN_W-1:0]      short_table [PIN_COUNT];
  logic [PIN_W-1:0]      drive;
  logic                  active;
  mode_t                 mode;
  logic [PIN_W-1:0]      cursor;
  logic [PIN_W-1:0]      partner;
  logic [PIN_W-1:0]      walk;
  logic [PIN_W-1:0]      cnt;
  logic [PIN_W-1:0]      part_acc;
  logic                  find_end;
  logic [LEVEL_BITS-1:0] levels_r;

  logic [PIN_W-1:0]      walk_m1, drive_m1, table_rd, part_final, walk_wrap, from_wrap;
  logic [PIN_W:0]        from_sum;
  logic [2**PIN_W-1:0]   lv_bits;
  logic                  hit, step_ok;

  // Shared test unit: one pin per cycle, either a level bit or a table entry.
  assign walk_m1  = walk - PIN_ONE;
  assign drive_m1 = drive - PIN_ONE;
  assign table_rd = short_table[walk_m1[IDX_W-1:0]];
  assign lv_bits  = {{LV_PAD{1'b0}}, levels_r};
  assign hit      = (state == ST_FIND) ? (table_rd != '0)
                                       : ((walk != drive) && lv_bits[walk_m1]);
  assign part_final = hit ? walk : part_acc;
  assign walk_wrap  = (walk == LAST_PIN) ? PIN_ONE : walk + PIN_ONE;
  assign from_sum   = {1'b0, cursor} + {{PIN_W{1'b0}}, 1'b1};
  assign from_wrap  = (from_sum > {1'b0, LAST_PIN}) ? PIN_ONE : from_sum[PIN_W-1:0];
  assign step_ok    = !active && (mode == MODE_SHORT);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (op_t'(op))
            OP_PROBE: state_next = active ? ST_PROBE : ST_EMIT;
            OP_STEP:  state_next = step_ok ? ST_FIND : ST_EMIT;
            default:  state_next = ST_EMIT;
          endcase
        end
      end
      ST_PROBE: begin
        if (walk == LAST_PIN) state_next = (drive == LAST_PIN) ? ST_FIND : ST_EMIT;
      end
      ST_FIND: begin
        if (hit || cnt == LAST_STEP) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stat.ready = (state == ST_IDLE);
    stat.emit  = (state == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive    <= '0;
      active   <= 1'b0;
      mode     <= MODE_NONE;
      cursor   <= '0;
      partner  <= '0;
      walk     <= PIN_ONE;
      cnt      <= '0;
      part_acc <= '0;
      find_end <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            case (op_t'(op))
              OP_START: begin
                drive  <= PIN_ONE;
                active <= 1'b1;
                mode   <= MODE_NONE;
                cursor <= '0;
              end
              OP_STEP: begin
                if (step_ok) begin
                  walk     <= from_wrap;
                  cnt      <= '0;
                  find_end <= 1'b0;
                end
              end
              OP_PROBE: begin
                if (active) begin
                  levels_r <= levels;
                  walk     <= PIN_ONE;
                  part_acc <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_PROBE: begin
          part_acc <= part_final;
          if (walk == LAST_PIN) begin
            if (drive == LAST_PIN) begin
              // last pin driven: end the scan and look for the first short
              active   <= 1'b0;
              drive    <= '0;
              walk     <= PIN_ONE;
              cnt      <= '0;
              find_end <= 1'b1;
            end else begin
              drive <= drive + PIN_ONE;
            end
          end else begin
            walk <= walk + PIN_ONE;
          end
        end
        ST_FIND: begin
          if (hit) begin
            cursor  <= walk;
            partner <= table_rd;
            if (find_end) mode <= MODE_SHORT;
          end else if (cnt == LAST_STEP) begin
            if (find_end) begin
              mode   <= MODE_OK;
              cursor <= '0;
            end
          end else begin
            walk <= walk_wrap;
            cnt  <= cnt + PIN_ONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Every entry is rewritten during a scan before the table is walked.
  always_ff @(posedge clk) begin
    if (state == ST_PROBE && walk == LAST_PIN)
      short_table[drive_m1[IDX_W-1:0]] <= part_final;
  end

  always_comb begin
    shown.mode    = mode;
    shown.pin     = (mode == MODE_SHORT) ? cursor : '0;
    shown.partner = (mode == MODE_SHORT) ? partner : '0;
  end

  assign drive_pin = active ? drive : '0;
  assign scanning  = active;

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (drive >= PIN_ONE && drive <= LAST_PIN))
    else $error("drive pin out of range during scan");

  a_idle_drive: assert property (@(posedge clk) disable iff (rst)
    !active |-> (drive == '0))
    else $error("drive pin nonzero while idle");

  a_short_valid: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_SHORT) |-> (cursor >= PIN_ONE && cursor <= LAST_PIN && partner != '0))
    else $error("shown short has no valid pin or partner");

  a_find_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIND) |-> !active)
    else $error("table walk while scan is active");

  a_probe_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && walk == LAST_PIN && drive != LAST_PIN) |=> (state == ST_EMIT))
    else $error("probe walk did not finish into emit");

endmodule

@@ hdl/cpss_disp.sv @@
// Display side: refresh register, digit multiplexer and segment decode of the shown result.
// Depends on cpss_pkg.
module cpss_disp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick,
  input  logic                            cfg_we,
  input  logic [cpss_pkg::REFRESH_W-1:0]  cfg_data,
  input  cpss_pkg::shown_t                shown,
  output logic [cpss_pkg::POS_W-1:0]      digit_select,
  output logic [cpss_pkg::SEG_W-1:0]      segment_bits
);
  import cpss_pkg::*;

  logic [REFRESH_W-1:0] refresh_period;
  logic [REFRESH_W-1:0] tick_counter;
  logic [POS_W-1:0]     digit_position;
  logic [REFRESH_W-1:0] period;
  logic [REFRESH_W:0]   cnt_inc;
  logic                 wrap;
  logic [3:0]           code;

  // A zero period acts as one.
  assign period  = (refresh_period == '0) ? REFRESH_W'(1) : refresh_period;
  assign cnt_inc = {1'b0, tick_counter} + (REFRESH_W + 1)'(1);
  assign wrap    = (cnt_inc >= {1'b0, period});

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period <= REFRESH_RESET;
      tick_counter   <= '0;
      digit_position <= '0;
    end else begin
      if (cfg_we) refresh_period <= cfg_data;
      if (tick) begin
        if (wrap) begin
          tick_counter   <= '0;
          digit_position <= digit_position + POS_W'(1);
        end else begin
          tick_counter <= cnt_inc[REFRESH_W-1:0];
        end
      end
    end
  end

  always_comb begin
    case (digit_position)
      2'd0:    code = tens_code(shown.pin);
      2'd1:    code = units_code(shown.pin);
      2'd2:    code = tens_code(shown.partner);
      default: code = units_code(shown.partner);
    endcase
  end

  // Blank everything while no result is shown.
  assign segment_bits = (shown.mode == MODE_NONE) ? '0 : glyph(code);
  assign digit_select = digit_position;

endmodule

@@ hdl/cable_pin_short_scanner_core.sv @@
// Top level of the cable pin short scanner: channel handshakes and result register.
// Depends on cpss_pkg, cpss_ifs, cpss_seq and cpss_disp.
//
// Usage: each request on item carries an op (tick, start, step, probe) and the
// sampled pin levels; every request yields exactly one request on result with
// the drive pin, scan flag, lit digit, its segments and the shown short.
// A start clears the result and drives pin 1; send one probe per driven pin
// with the levels seen while drive_pin is high. After the last probe the
// first short (or "0 0" for a clean cable) is displayed; step walks the shorts.
// Sequence: tick, start and ignored requests go from idle straight to the emit
// state and into the output register. A probe walks all PIN_COUNT pins through
// the shared test unit; the last probe of a scan and a step then also walk the
// short table one pin per cycle until the first short or a full round, then emit.
// item.ready is high only while the sequencer is idle; one request is in work.
// A finished result sits in the output register; if the receiver stalls, the
// next request is still taken and its result waits until the register frees.
// cfg writes refresh_period (ticks per digit advance) and is always ready.
// Reset (rst, synchronous) clears the scan, hides the display and sets the
// refresh period to 6. No clearing pass is needed after reset.
module cable_pin_short_scanner_core #(
  parameter int PIN_COUNT = 19
) (
  input  logic          clk,
  input  logic          rst,
  cpss_item_if.sink     item,
  cpss_result_if.source result,
  cpss_cfg_if.sink      cfg
);
  import cpss_pkg::*;

  seq_stat_t        stat;
  shown_t           shown;
  logic [PIN_W-1:0] drive_pin;
  logic             scanning;
  logic [POS_W-1:0] digit_select;
  logic [SEG_W-1:0] segment_bits;
  logic             acc, take, load, out_valid;

  assign item.ready = stat.ready;
  assign acc        = item.valid && item.ready;
  assign cfg.ready  = 1'b1;
  assign take       = !out_valid || result.ready;
  assign load       = stat.emit && take;

  cpss_seq #(
    .PIN_COUNT(PIN_COUNT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .op        (item.op),
    .levels    (item.levels),
    .take      (take),
    .stat      (stat),
    .shown     (shown),
    .drive_pin (drive_pin),
    .scanning  (scanning)
  );

  cpss_disp u_disp (
    .clk          (clk),
    .rst          (rst),
    .tick         (acc && (item.op == OP_TICK)),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.data),
    .shown        (shown),
    .digit_select (digit_select),
    .segment_bits (segment_bits)
  );

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (load)         out_valid <= 1'b1;
    else if (result.ready) out_valid <= 1'b0;
  end

  // Capture the block state as it stands after the request's update.
  always_ff @(posedge clk) begin
    if (load) begin
      result.drive_pin     <= drive_pin;
      result.scanning      <= scanning;
      result.digit_select  <= digit_select;
      result.segment_bits  <= segment_bits;
      result.shown_pin     <= shown.pin;
      result.shown_partner <= shown.partner;
      result.all_ok        <= (shown.mode == MODE_OK);
    end
  end

  assign result.valid = out_valid;

endmodule
